// ===== hw/rtl/supersampled_ring_disc_shader_top_macros.svh =====
// Assertion macros for the ring and disc shader.
`ifndef SUPERSAMPLED_RING_DISC_SHADER_TOP_MACROS_SVH
`define SUPERSAMPLED_RING_DISC_SHADER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Implication in the same cycle, off during reset.
`define SSRD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssrd assertion failed");
// Implication into the next cycle, off during reset.
`define SSRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssrd assertion failed");
// Implication into the next cycle, checked in reset too.
`define SSRD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ssrd assertion failed");
`else
`define SSRD_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define SSRD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define SSRD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons)
`endif

`endif

// ===== hw/rtl/ssrd_pkg.sv =====
`default_nettype none
package ssrd_pkg;

  localparam int SUBSAMPLES_DEFAULT = 4;
  localparam int SUB_STEP           = 10;
  localparam int SUB_HALF           = 5;

  localparam int PIX_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int COORD_W    = 14;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int RAD_W      = 10;
  localparam int RSQ_W      = 24;
  localparam int R_W        = 5;
  localparam int G_W        = 6;
  localparam int B_W        = 5;
  localparam int ACC_R_W    = 9;
  localparam int ACC_G_W    = 10;
  localparam int ACC_B_W    = 9;
  localparam int ACC_R_MAX  = 496;
  localparam int ACC_G_MAX  = 1008;
  localparam int ACC_B_MAX  = 496;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam int CENTER_POS_RST  = 11;
  localparam int DISC_RADIUS_RST = 61;
  localparam int RING_RADIUS_RST = 103;
  localparam logic [COLOR_W-1:0] DISC_COLOR_RST = 16'h42FF;
  localparam logic [COLOR_W-1:0] RING_COLOR_RST = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_POS  = 3'd0,
    REG_DISC_RADIUS = 3'd1,
    REG_RING_RADIUS = 3'd2,
    REG_DISC_COLOR  = 3'd3,
    REG_RING_COLOR  = 3'd4
  } ssrd_reg_t;

  typedef struct packed {
    logic [COORD_W-1:0] centre;
    logic [RSQ_W-1:0]   disc_r2;
    logic [RSQ_W-1:0]   ring_r2;
    logic [COLOR_W-1:0] disc_color;
    logic [COLOR_W-1:0] ring_color;
  } ssrd_cfg_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x_base;
    logic [COORD_W-1:0] y_base;
    logic [COLOR_W-1:0] bg;
    logic [ACC_R_W-1:0] acc_r;
    logic [ACC_G_W-1:0] acc_g;
    logic [ACC_B_W-1:0] acc_b;
  } ssrd_bundle_t;

endpackage
`default_nettype wire

// ===== hw/rtl/supersampled_ring_disc_shader_top.sv =====
// An input transaction passes through every subsample cell in turn to the result register.
// Throughput: one pixel per cycle unless held; every subsample cell is a 4-stage pipeline.
// The whole chain holds while a finished result waits and is not taken.
// Reset (rst, synchronous, active high) empties the chain and loads the
// register defaults: centre 11, radii 61 and 103 tenths, colours 0x42FF and 0xFFFF.
`default_nettype none
`include "supersampled_ring_disc_shader_top_macros.svh"
module supersampled_ring_disc_shader_top (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ssrd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [ssrd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // pixel input channel
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  logic [ssrd_pkg::PIX_W-1:0]          pix_x,
  input  logic [ssrd_pkg::PIX_W-1:0]          pix_y,
  input  logic [ssrd_pkg::COLOR_W-1:0]        bg_color,
  // result channel
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic [ssrd_pkg::COLOR_W-1:0]        pixel_color
);

  // Subsample grid is fixed by the package: sum widths and radius widths
  // are sized for it.
  localparam int SUBSAMPLES = ssrd_pkg::SUBSAMPLES_DEFAULT;
  localparam int CW        = ssrd_pkg::COORD_W;
  localparam int RSW       = ssrd_pkg::RSQ_W;
  localparam int NCELLS    = SUBSAMPLES * SUBSAMPLES;
  localparam int SUB_UNIT  = ssrd_pkg::SUB_STEP * SUBSAMPLES;
  localparam int SUM_SHIFT = $clog2(NCELLS);

  localparam logic [CW-1:0] CENTRE_RST =
    CW'(ssrd_pkg::CENTER_POS_RST * SUB_UNIT + SUB_UNIT / 2);
  localparam logic [RSW-1:0] DISC_R2_RST =
    RSW'((ssrd_pkg::DISC_RADIUS_RST * SUBSAMPLES) * (ssrd_pkg::DISC_RADIUS_RST * SUBSAMPLES));
  localparam logic [RSW-1:0] RING_R2_RST =
    RSW'((ssrd_pkg::RING_RADIUS_RST * SUBSAMPLES) * (ssrd_pkg::RING_RADIUS_RST * SUBSAMPLES));

  ssrd_pkg::ssrd_cfg_t cfg;
  logic [2*ssrd_pkg::RAD_W-1:0] rad_sq;
  logic [CW-1:0] centre_wr;

  // Chain link k feeds cell k; the last link is the result register.
  ssrd_pkg::ssrd_bundle_t chain [NCELLS+1];
  ssrd_pkg::ssrd_bundle_t head;
  logic advance;

  // Registers are kept in the form the cells need: centre in subsample units
  // and radii already squared, so no cell multiplies configuration values.
  assign rad_sq = (2*ssrd_pkg::RAD_W)'(cfg_data[ssrd_pkg::RAD_W-1:0]) *
                  (2*ssrd_pkg::RAD_W)'(cfg_data[ssrd_pkg::RAD_W-1:0]);
  assign centre_wr = CW'(CW'(cfg_data[ssrd_pkg::PIX_W-1:0]) * CW'(SUB_UNIT) +
                         CW'(SUB_UNIT / 2));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre     <= CENTRE_RST;
      cfg.disc_r2    <= DISC_R2_RST;
      cfg.ring_r2    <= RING_R2_RST;
      cfg.disc_color <= ssrd_pkg::DISC_COLOR_RST;
      cfg.ring_color <= ssrd_pkg::RING_COLOR_RST;
    end else if (cfg_we) begin
      unique case (ssrd_pkg::ssrd_reg_t'(cfg_index))
        ssrd_pkg::REG_CENTER_POS:  cfg.centre     <= centre_wr;
        ssrd_pkg::REG_DISC_RADIUS: cfg.disc_r2    <= RSW'(RSW'(rad_sq) << SUM_SHIFT);
        ssrd_pkg::REG_RING_RADIUS: cfg.ring_r2    <= RSW'(RSW'(rad_sq) << SUM_SHIFT);
        ssrd_pkg::REG_DISC_COLOR:  cfg.disc_color <= cfg_data;
        ssrd_pkg::REG_RING_COLOR:  cfg.ring_color <= cfg_data;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Advance the whole chain unless a finished result is waiting; hold
  // everything otherwise, so a waiting result holds the input channel too.
  assign advance   = !chain[NCELLS].valid || res_ready;
  assign pix_ready = advance;

  // Feed the head of the chain: pixel origin in subsample units, empty sums.
  always_comb begin
    head.valid  = pix_valid;
    head.x_base = CW'(CW'(pix_x) * CW'(SUB_UNIT));
    head.y_base = CW'(CW'(pix_y) * CW'(SUB_UNIT));
    head.bg     = bg_color;
    head.acc_r  = '0;
    head.acc_g  = '0;
    head.acc_b  = '0;
  end

  assign chain[0] = head;

  // One cell per subsample, row by row; each adds its colour to the sums.
  for (genvar r = 0; r < SUBSAMPLES; r++) begin : g_row
    for (genvar c = 0; c < SUBSAMPLES; c++) begin : g_col
      ssrd_cell #(
        .ROW(r),
        .COL(c)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .advance (advance),
        .cfg     (cfg),
        .din     (chain[r*SUBSAMPLES+c]),
        .dout    (chain[r*SUBSAMPLES+c+1])
      );
    end
  end

  // Average over the subsamples (truncating shift) and repack RGB565.
  assign res_valid   = chain[NCELLS].valid;
  assign pixel_color = {ssrd_pkg::R_W'(chain[NCELLS].acc_r >> SUM_SHIFT),
                        ssrd_pkg::G_W'(chain[NCELLS].acc_g >> SUM_SHIFT),
                        ssrd_pkg::B_W'(chain[NCELLS].acc_b >> SUM_SHIFT)};

  // Reset empties the result register.
  `SSRD_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !res_valid)
  // A stalled chain keeps its first cell's transaction intact.
  `SSRD_ASSERT_NEXT(a_stall_holds, clk, rst, !advance && chain[1].valid,
                    chain[1].valid && $stable(chain[1]))
  // Channel sums never pass sixteen full-scale samples.
  `SSRD_ASSERT_IMPL(a_sum_bound, clk, rst, res_valid,
                    (chain[NCELLS].acc_r <= ssrd_pkg::ACC_R_W'(ssrd_pkg::ACC_R_MAX)) &&
                    (chain[NCELLS].acc_g <= ssrd_pkg::ACC_G_W'(ssrd_pkg::ACC_G_MAX)) &&
                    (chain[NCELLS].acc_b <= ssrd_pkg::ACC_B_W'(ssrd_pkg::ACC_B_MAX)))

endmodule
`default_nettype wire

// ===== hw/rtl/ssrd_cell.sv =====
`default_nettype none
module ssrd_cell #(
  parameter int ROW = 0,
  parameter int COL = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  ssrd_pkg::ssrd_cfg_t    cfg,
  input  ssrd_pkg::ssrd_bundle_t din,
  output ssrd_pkg::ssrd_bundle_t dout
);

  localparam int CW = ssrd_pkg::COORD_W;
  localparam int SW = ssrd_pkg::SQ_W;
  localparam int DW = ssrd_pkg::DIST_W;
  localparam logic [CW-1:0] X_OFF =
    CW'(COL * ssrd_pkg::SUB_STEP + ssrd_pkg::SUB_HALF);
  localparam logic [CW-1:0] Y_OFF =
    CW'(ROW * ssrd_pkg::SUB_STEP + ssrd_pkg::SUB_HALF);

  // stage a: distances along each axis
  logic [CW-1:0] sx, sy, dx_next, dy_next;
  ssrd_pkg::ssrd_bundle_t b_a;
  logic [CW-1:0] dx_a, dy_a;

  // stage b: squares
  ssrd_pkg::ssrd_bundle_t b_b;
  logic [SW-1:0] dxsq_b, dysq_b;

  // stage c: radius tests
  logic [DW-1:0] d2;
  ssrd_pkg::ssrd_bundle_t b_c;
  logic in_disc_c, in_ring_c;

  // stage d: colour select and accumulate
  logic [ssrd_pkg::COLOR_W-1:0] colour;
  ssrd_pkg::ssrd_bundle_t dout_next;

  always_comb begin
    sx = din.x_base + X_OFF;
    sy = din.y_base + Y_OFF;
    dx_next = (sx >= cfg.centre) ? (sx - cfg.centre) : (cfg.centre - sx);
    dy_next = (sy >= cfg.centre) ? (sy - cfg.centre) : (cfg.centre - sy);
  end

  assign d2 = DW'(dxsq_b) + DW'(dysq_b);

  always_comb begin
    if (in_disc_c) begin
      colour = cfg.disc_color;
    end else if (in_ring_c) begin
      colour = cfg.ring_color;
    end else begin
      colour = b_c.bg;
    end
    dout_next = b_c;
    dout_next.acc_r = b_c.acc_r + ssrd_pkg::ACC_R_W'(colour[15:11]);
    dout_next.acc_g = b_c.acc_g + ssrd_pkg::ACC_G_W'(colour[10:5]);
    dout_next.acc_b = b_c.acc_b + ssrd_pkg::ACC_B_W'(colour[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_a.valid  <= 1'b0;
      b_b.valid  <= 1'b0;
      b_c.valid  <= 1'b0;
      dout.valid <= 1'b0;
    end else if (advance) begin
      b_a  <= din;
      b_b  <= b_a;
      b_c  <= b_b;
      dout <= dout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dx_a      <= dx_next;
      dy_a      <= dy_next;
      dxsq_b    <= SW'(dx_a) * SW'(dx_a);
      dysq_b    <= SW'(dy_a) * SW'(dy_a);
      in_disc_c <= (d2 <= DW'(cfg.disc_r2));
      in_ring_c <= (d2 <= DW'(cfg.ring_r2));
    end
  end

endmodule
`default_nettype wire

// ===== test/supersampled_ring_disc_shader_top_test.sv =====
`default_nettype none
module supersampled_ring_disc_shader_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUBS        = ssrd_pkg::SUBSAMPLES_DEFAULT;
  localparam int SUB_STEP    = ssrd_pkg::SUB_STEP;
  localparam int SUB_HALF    = ssrd_pkg::SUB_HALF;
  localparam int CFG_INDEX_W = ssrd_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = ssrd_pkg::CFG_DATA_W;
  localparam int PIX_W       = ssrd_pkg::PIX_W;
  localparam int COLOR_W     = ssrd_pkg::COLOR_W;
  localparam int RAD_W       = ssrd_pkg::RAD_W;
  localparam int R_W         = ssrd_pkg::R_W;
  localparam int G_W         = ssrd_pkg::G_W;
  localparam int B_W         = ssrd_pkg::B_W;
  localparam int CELL        = SUB_STEP * SUBS;   // one pixel in 1/40 units
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 80;                // idle wait after draining, to catch stray results

  // Indexes past the last register; the block must ignore writes to them.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   pix_valid = 1'b0;
  logic                   pix_ready;
  logic [PIX_W-1:0]       pix_x     = '0;
  logic [PIX_W-1:0]       pix_y     = '0;
  logic [COLOR_W-1:0]     bg_color  = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  logic [COLOR_W-1:0]     pixel_color;

  supersampled_ring_disc_shader_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix_x       (pix_x),
    .pix_y       (pix_y),
    .bg_color    (bg_color),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .pixel_color (pixel_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the register file, updated at the edge that writes it.
  logic [PIX_W-1:0]   centre_cell = PIX_W'(ssrd_pkg::CENTER_POS_RST);
  logic [RAD_W-1:0]   disc_tenths = RAD_W'(ssrd_pkg::DISC_RADIUS_RST);
  logic [RAD_W-1:0]   ring_tenths = RAD_W'(ssrd_pkg::RING_RADIUS_RST);
  logic [COLOR_W-1:0] disc_rgb    = ssrd_pkg::DISC_COLOR_RST;
  logic [COLOR_W-1:0] ring_rgb    = ssrd_pkg::RING_COLOR_RST;

  logic [COLOR_W-1:0] expected_colours[$];
  logic [COLOR_W-1:0] oldest_colour;
  int                 mismatches  = 0;
  int                 cycle_count = 0;

  // Steady mode switches off idling on both sides; hold_request asks the
  // receiver for one long hold-off.
  bit steady       = 1'b0;
  bit hold_request = 1'b0;
  int hold_left    = 0;

  // Blend the 16 subsamples of one pixel into an RGB565 colour.
  function automatic logic [COLOR_W-1:0] shade_pixel(input logic [PIX_W-1:0] x,
                                                      input logic [PIX_W-1:0] y,
                                                      input logic [COLOR_W-1:0] bg);
    int unsigned dr, rr, disc_lim, ring_lim, mid;
    int unsigned sx, sy, dx, dy, dist2;
    int unsigned sum_r, sum_g, sum_b;
    logic [COLOR_W-1:0] pick;
    dr = 32'(disc_tenths);
    dr = dr * SUBS;
    rr = 32'(ring_tenths);
    rr = rr * SUBS;
    disc_lim = dr * dr;
    ring_lim = rr * rr;
    mid = 32'(centre_cell);
    mid = mid * CELL + CELL / 2;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int i = 0; i < SUBS; i++) begin
      for (int j = 0; j < SUBS; j++) begin
        sx = 32'(x);
        sx = sx * CELL + j * SUB_STEP + SUB_HALF;
        sy = 32'(y);
        sy = sy * CELL + i * SUB_STEP + SUB_HALF;
        dx = (sx >= mid) ? sx - mid : mid - sx;
        dy = (sy >= mid) ? sy - mid : mid - sy;
        dist2 = dx * dx + dy * dy;
        // The disc test comes first, so an undersized ring is simply hidden.
        if (dist2 <= disc_lim) begin
          pick = disc_rgb;
        end else if (dist2 <= ring_lim) begin
          pick = ring_rgb;
        end else begin
          pick = bg;
        end
        sum_r += 32'(pick[15:11]);
        sum_g += 32'(pick[10:5]);
        sum_b += 32'(pick[4:0]);
      end
    end
    return {R_W'(sum_r / (SUBS * SUBS)), G_W'(sum_g / (SUBS * SUBS)),
            B_W'(sum_b / (SUBS * SUBS))};
  endfunction

  // Offer one pixel, hold it until the transaction completes, then queue its
  // predicted colour. Valid stays high on return so back-to-back pixels flow.
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                            input logic [COLOR_W-1:0] bg);
    while (!steady && $urandom_range(0, 99) < 17) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_x     <= x;
    pix_y     <= y;
    bg_color  <= bg;
    do @(posedge clk); while (!pix_ready);
    expected_colours.push_back(shade_pixel(x, y, bg));
  endtask

  // Write one register; the caller drops cfg_we after the last write of a batch.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      ssrd_pkg::REG_CENTER_POS:  centre_cell = data[PIX_W-1:0];
      ssrd_pkg::REG_DISC_RADIUS: disc_tenths = data[RAD_W-1:0];
      ssrd_pkg::REG_RING_RADIUS: ring_tenths = data[RAD_W-1:0];
      ssrd_pkg::REG_DISC_COLOR:  disc_rgb    = data;
      ssrd_pkg::REG_RING_COLOR:  ring_rgb    = data;
      default: ;
    endcase
  endtask

  // Load all five registers, with junk above the centre and radius fields.
  task automatic load_registers(input logic [PIX_W-1:0] centre, input logic [RAD_W-1:0] disc,
                                input logic [RAD_W-1:0] ring, input logic [COLOR_W-1:0] dcol,
                                input logic [COLOR_W-1:0] rcol);
    write_reg(ssrd_pkg::REG_CENTER_POS, {8'($urandom), centre});
    write_reg(ssrd_pkg::REG_DISC_RADIUS, {6'($urandom), disc});
    write_reg(ssrd_pkg::REG_RING_RADIUS, {6'($urandom), ring});
    write_reg(ssrd_pkg::REG_DISC_COLOR, dcol);
    write_reg(ssrd_pkg::REG_RING_COLOR, rcol);
    cfg_we <= 1'b0;
  endtask

  // Drop valid and wait until every queued colour has come back.
  task automatic wait_drained();
    pix_valid <= 1'b0;
    while (expected_colours.size() != 0) @(posedge clk);
  endtask

  // Random pixels, three in four clustered round the circle so that the
  // disc and ring edges are crossed often.
  task automatic send_random_pixels(input int count);
    int span;
    int off_x;
    int off_y;
    logic [COLOR_W-1:0] bg;
    for (int n = 0; n < count; n++) begin
      span  = (ring_tenths > disc_tenths ? ring_tenths : disc_tenths) / 10 + 3;
      off_x = int'($urandom_range(0, 2 * span)) - span;
      off_y = int'($urandom_range(0, 2 * span)) - span;
      case ($urandom_range(0, 7))
        0:       bg = '0;
        1:       bg = '1;
        default: bg = COLOR_W'($urandom);
      endcase
      if ($urandom_range(0, 3) != 0) begin
        send_pixel(PIX_W'(int'(centre_cell) + off_x), PIX_W'(int'(centre_cell) + off_y), bg);
      end else begin
        send_pixel(PIX_W'($urandom), PIX_W'($urandom), bg);
      end
    end
  endtask

  // Reset values: disc centre, both edges, the ring band and far corners.
  task automatic test_default_shading();
    send_pixel(8'd11, 8'd11, 16'h0000);
    send_pixel(8'd11, 8'd11, 16'hFFFF);
    send_pixel(8'd0, 8'd0, 16'h0000);
    send_pixel(8'd255, 8'd255, 16'hFFFF);
    send_pixel(8'd0, 8'd255, 16'h5555);
    send_pixel(8'd255, 8'd0, 16'hAAAA);
    send_pixel(8'd11, 8'd17, 16'h0000);
    send_pixel(8'd11, 8'd21, 16'h1234);
    send_pixel(8'd4, 8'd11, 16'hF81F);
  endtask

  // Writes to unused indexes, masking of wide data, zero radius and a ring
  // smaller than the disc.
  task automatic test_register_writes();
    wait_drained();
    for (int i = int'(REG_SPARE_FIRST); i <= int'(REG_SPARE_LAST); i++) begin
      write_reg(CFG_INDEX_W'(i), 16'hFFFF);
    end
    cfg_we <= 1'b0;
    send_pixel(8'd11, 8'd11, 16'h0000);
    send_pixel(8'd14, 8'd11, 16'h0000);

    // Centre in the corner, zero-radius disc, widest ring.
    wait_drained();
    write_reg(ssrd_pkg::REG_CENTER_POS, 16'hFF00);
    write_reg(ssrd_pkg::REG_DISC_RADIUS, 16'hFC00);
    write_reg(ssrd_pkg::REG_RING_RADIUS, 16'h03FF);
    write_reg(ssrd_pkg::REG_DISC_COLOR, 16'h0000);
    write_reg(ssrd_pkg::REG_RING_COLOR, 16'hFFFF);
    cfg_we <= 1'b0;
    send_pixel(8'd0, 8'd0, 16'h1234);
    send_pixel(8'd255, 8'd255, 16'h0000);
    send_pixel(8'd0, 8'd102, 16'hF800);

    // Centre at the far corner, widest disc, ring hidden under it.
    wait_drained();
    write_reg(ssrd_pkg::REG_CENTER_POS, 16'hFFFF);
    write_reg(ssrd_pkg::REG_DISC_RADIUS, 16'hFFFF);
    write_reg(ssrd_pkg::REG_RING_RADIUS, 16'h0005);
    write_reg(ssrd_pkg::REG_DISC_COLOR, 16'hFFFF);
    write_reg(ssrd_pkg::REG_RING_COLOR, 16'h07E0);
    cfg_we <= 1'b0;
    send_pixel(8'd255, 8'd255, 16'h0000);
    send_pixel(8'd200, 8'd255, 16'h0000);
    send_pixel(8'd150, 8'd150, 16'hFFFF);

    // Both radii zero: background everywhere.
    wait_drained();
    load_registers(8'd128, 10'd0, 10'd0, 16'hFFFF, 16'hFFFF);
    send_pixel(8'd128, 8'd128, 16'h0000);
    send_pixel(8'd127, 8'd127, 16'h001F);
  endtask

  // Several register settings, extremes first, each with a random batch.
  task automatic test_random_settings();
    logic [PIX_W-1:0]   centre;
    logic [RAD_W-1:0]   disc;
    logic [RAD_W-1:0]   ring;
    logic [COLOR_W-1:0] dcol;
    logic [COLOR_W-1:0] rcol;
    for (int phase = 0; phase < 6; phase++) begin
      centre = PIX_W'($urandom);
      disc   = RAD_W'($urandom_range(0, 250));
      ring   = RAD_W'($urandom_range(0, 300));
      dcol   = COLOR_W'($urandom);
      rcol   = COLOR_W'($urandom);
      case (phase)
        0: begin
          centre = '0;
          disc   = '0;
          ring   = '1;
        end
        1: begin
          centre = '1;
          disc   = '1;
          ring   = '0;
        end
        2: begin
          dcol = '0;
          rcol = '1;
        end
        3: begin
          dcol = '1;
          rcol = '0;
          ring = RAD_W'($urandom);
        end
        default: ;
      endcase
      wait_drained();
      load_registers(centre, disc, ring, dcol, rcol);
      send_random_pixels(130);
    end
  endtask

  // Full-rate stream with no idling on either side.
  task automatic test_steady_stream();
    steady = 1'b1;
    send_random_pixels(120);
    steady = 1'b0;
  endtask

  // Receiver holds off for a long stretch while pixels keep coming, so the
  // pipeline fills and pix_ready has to fall.
  task automatic test_result_backpressure();
    hold_request = 1'b1;
    send_random_pixels(200);
  endtask

  // Receiver: random stalls, a counted hold-off on request, none when steady.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left != 0) begin
      res_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      res_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      res_ready <= steady || ($urandom_range(0, 99) >= 17);
    end
  end

  // Compare each result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (expected_colours.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, pixel_color);
      end else begin
        oldest_colour = expected_colours.pop_front();
        if (pixel_color !== oldest_colour) begin
          mismatches++;
          $display("%0t: pixel_color expected %h, actual %h", $time, oldest_colour,
                   pixel_color);
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_shading();
    test_register_writes();
    test_random_settings();
    test_steady_stream();
    test_result_backpressure();
    wait_drained();
    // Keep the clock running after draining to catch any stray result.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
